@@ rtl/aswpa_pkg.sv @@
package aswpa_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_WRITE = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ rtl/aswpa_ctrl.sv @@
module aswpa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output logic                  out_valid,
  output aswpa_pkg::ctrl_cmd_t  cmd
);

  aswpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aswpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      aswpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = aswpa_pkg::S_EXEC;
        end
      end
      aswpa_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = aswpa_pkg::S_RESP;
      end
      aswpa_pkg::S_RESP: begin
        out_valid = 1'b1;
        state_nxt = aswpa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = aswpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/aswpa_datapath.sv @@
module aswpa_datapath #(
  parameter int DEPTH      = aswpa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aswpa_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aswpa_pkg::ctrl_cmd_t          cmd,
  input  logic [aswpa_pkg::OP_W-1:0]    in_op,
  input  logic [DATA_WIDTH-1:0]         in_value,
  input  logic [CNT_W-1:0]              in_position,
  output logic [DATA_WIDTH-1:0]         out_read_data,
  output logic [aswpa_pkg::STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0]  mem_r [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_q_r;
  logic [aswpa_pkg::OP_W-1:0] op_r;
  logic [DATA_WIDTH-1:0]  value_r;
  logic [CNT_W-1:0]       pos_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  aswpa_pkg::status_t     status_r, status_nxt;
  logic                   rd_ok_r;

  logic                   empty;
  logic                   full;
  logic                   pos_bad;
  logic [CNT_W-1:0]       pos_idx;
  logic [CNT_W-1:0]       top_idx;
  logic [AW-1:0]          addr;
  logic                   mem_we;
  logic                   mem_re;

  assign empty   = (count_r == '0);
  assign full    = (count_r == DEPTH_C);
  assign pos_bad = (pos_r == '0) || (pos_r > count_r);
  assign pos_idx = count_r - pos_r;
  assign top_idx = count_r - CNT_W'(1);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = aswpa_pkg::ST_OK;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    addr       = count_r[AW-1:0];
    case (op_r)
      aswpa_pkg::OP_PUSH: begin
        if (full) begin
          status_nxt = aswpa_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      aswpa_pkg::OP_POP: begin
        addr = top_idx[AW-1:0];
        if (empty) begin
          status_nxt = aswpa_pkg::ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          count_nxt = top_idx;
        end
      end
      aswpa_pkg::OP_PEEK, aswpa_pkg::OP_WRITE: begin
        addr = pos_idx[AW-1:0];
        if (empty) begin
          status_nxt = aswpa_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          status_nxt = aswpa_pkg::ST_RANGE;
        end else if (op_r == aswpa_pkg::OP_PEEK) begin
          mem_re = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
      end
      aswpa_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Single-port entry store: one write or one read per operation.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem_r[addr] <= value_r;
    end
    if (cmd.exec && mem_re) begin
      rd_q_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_ok_r <= 1'b0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      rd_ok_r <= mem_re;
    end
  end

  assign out_read_data   = rd_ok_r ? rd_q_r : '0;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = (count_r == '0);
  assign out_is_full     = (count_r == DEPTH_C);

endmodule

@@ rtl/array_stack_with_positional_access_unit.sv @@
// LIFO stack of DEPTH words with push, pop, peek and overwrite by position
// counted from the top (1 is the top entry), and clear.
// Input channel: an operation is transferred at a rising edge where start is
// high and busy is low; in_op, in_value and in_position are sampled there.
// Result channel: every operation yields one result, shown for exactly one
// cycle with out_valid high: read data, status, entry count and the empty
// and full flags after the operation. The receiver cannot stall the block,
// so a result is taken in the cycle it appears.
// Sequence: the command is captured at the input transfer, the single access
// to the entry memory is made in the execute state, and the result is shown
// in the response state that follows; busy falls in the cycle after the
// result. A new operation can be transferred only after the previous result
// has been presented.
// Reset (rst_n low, synchronous) empties the stack and returns the block to
// idle. The entry memory itself is not cleared; only entries below the
// count are ever read.
module array_stack_with_positional_access_unit #(
  parameter int DEPTH      = aswpa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aswpa_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [aswpa_pkg::OP_W-1:0]     in_op,
  input  logic [DATA_WIDTH-1:0]          in_value,
  input  logic [CNT_W-1:0]               in_position,
  output logic                           out_valid,
  output logic [DATA_WIDTH-1:0]          out_read_data,
  output logic [aswpa_pkg::STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]               out_entry_count,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  aswpa_pkg::ctrl_cmd_t cmd;

  aswpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  aswpa_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

import aswpa_pkg::*;

localparam int STACK_DEPTH = DEPTH_DEF;
localparam int WORD_W      = DATA_WIDTH_DEF;
localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(OP_CLEAR + 1);
localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

typedef struct {
  logic [WORD_W-1:0]  read_data;
  status_t            status;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic               is_full;
} stack_result_t;

// Tracks the stack contents on every accepted operation and holds the
// results that the block still owes, oldest first.
class stack_tracker;
  logic [WORD_W-1:0] words [STACK_DEPTH];
  int unsigned       depth_used;
  stack_result_t     owed [$];
  int unsigned       errors;

  function new();
    depth_used = 0;
    errors     = 0;
  endfunction

  function int unsigned pending();
    return owed.size();
  endfunction

  function void note_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                        logic [COUNT_W-1:0] position);
    stack_result_t r;
    int unsigned   idx;
    r.read_data = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH: begin
        if (depth_used >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          words[depth_used] = value;
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) r.status = ST_EMPTY;
        else begin
          depth_used--;
          r.read_data = words[depth_used];
        end
      end
      OP_PEEK, OP_WRITE: begin
        // The empty check wins over the position check.
        if (depth_used == 0) r.status = ST_EMPTY;
        else if (position == 0 || position > depth_used) r.status = ST_RANGE;
        else begin
          idx = depth_used - position;
          if (op == OP_PEEK) r.read_data = words[idx];
          else words[idx] = value;
        end
      end
      OP_CLEAR: depth_used = 0;
      default: ;
    endcase
    r.entry_count = COUNT_W'(depth_used);
    r.is_empty    = (depth_used == 0);
    r.is_full     = (depth_used == STACK_DEPTH);
    owed.push_back(r);
  endfunction

  function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endfunction

  function void check_result(logic [WORD_W-1:0] read_data, logic [STATUS_W-1:0] status,
                             logic [COUNT_W-1:0] entry_count, logic is_empty,
                             logic is_full);
    stack_result_t e;
    if (owed.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual data %0h status %0d",
               $time, read_data, status);
      return;
    end
    e = owed.pop_front();
    compare("read_data", 64'(e.read_data), 64'(read_data));
    compare("status", 64'(e.status), 64'(status));
    compare("entry_count", 64'(e.entry_count), 64'(entry_count));
    compare("is_empty", 64'(e.is_empty), 64'(is_empty));
    compare("is_full", 64'(e.is_full), 64'(is_full));
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_op = '0;
  logic [WORD_W-1:0]  in_value = '0;
  logic [COUNT_W-1:0] in_position = '0;
  logic               out_valid;
  logic [WORD_W-1:0]  out_read_data;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;
  logic               out_is_full;

  stack_tracker tracker = new();
  int unsigned  cycles = 0;

  array_stack_with_positional_access_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are checked before the new transfer is noted, although a
  // result can never belong to an operation taken at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_read_data, out_status, out_entry_count,
                           out_is_empty, out_is_full);
    if (rst_n && start && !busy)
      tracker.note_op(in_op, in_value, in_position);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a rising edge. Start stays high across back-to-back transfers.
  task automatic send_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                         logic [COUNT_W-1:0] position, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (busy);
  endtask

  // The transfer at the calling edge is noted by the monitor at that same
  // edge, so the task waits for a further edge before it trusts the owed count.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return WORD_W'($urandom);
  endfunction

  initial begin
    int unsigned      roll;
    int unsigned      push_weight;
    logic [OP_W-1:0]  op;
    logic [COUNT_W-1:0] pos;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill to the top with extreme and patterned words, then probe the limits.
    send_op(OP_PUSH, '0, '0, 0);
    send_op(OP_PUSH, '1, '0, 1);
    send_op(OP_PUSH, 32'hAAAA_AAAA, '0, 0);
    send_op(OP_PUSH, 32'h5555_5555, '0, 0);
    send_op(OP_PUSH, 32'h8000_0001, '0, 2);
    send_op(OP_PUSH, 32'h7FFF_FFFE, '0, 0);
    send_op(OP_PUSH, 32'h0123_4567, '0, 0);
    send_op(OP_PUSH, 32'hFEDC_BA98, '0, 0);
    send_op(OP_PUSH, 32'hDEAD_BEEF, '0, 0);
    send_op(OP_PEEK, '0, COUNT_W'(1), 0);
    send_op(OP_PEEK, '0, COUNT_W'(STACK_DEPTH), 0);
    send_op(OP_PEEK, '0, '0, 0);
    send_op(OP_PEEK, '0, COUNT_W'(STACK_DEPTH + 1), 0);
    send_op(OP_PEEK, '1, '1, 0);
    send_op(OP_WRITE, 32'hCAFE_F00D, COUNT_W'(1), 0);
    send_op(OP_WRITE, '1, COUNT_W'(STACK_DEPTH), 0);
    send_op(OP_WRITE, '1, '0, 0);
    send_op(OP_WRITE, 32'h1234_5678, COUNT_W'(12), 0);
    send_op(OP_POP, '0, '0, 0);
    send_op(OP_CLEAR, '0, '0, 3);
    send_op(OP_POP, '0, '0, 0);
    send_op(OP_PEEK, '0, COUNT_W'(1), 0);
    send_op(OP_WRITE, '1, COUNT_W'(1), 0);
    send_op(OP_UNUSED_LO, '1, '1, 0);
    send_op(OP_UNUSED_HI, '0, '0, 0);

    wait_drained();

    for (int i = 0; i < 700; i++) begin
      // Alternate between filling and draining so both full and empty recur.
      push_weight = ((i / 60) % 2 == 0) ? 55 : 20;
      roll = $urandom_range(0, 99);
      if (roll < push_weight) op = OP_PUSH;
      else if (roll < push_weight + 25) op = OP_POP;
      else if (roll < push_weight + 36) op = OP_PEEK;
      else if (roll < push_weight + 47) op = OP_WRITE;
      else if (roll < push_weight + 49) op = OP_CLEAR;
      else if (roll < push_weight + 51)
        op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else op = OP_PEEK;
      if ($urandom_range(0, 9) < 7) pos = COUNT_W'($urandom_range(1, STACK_DEPTH));
      else pos = COUNT_W'($urandom);
      send_op(op, pick_value(), pos, pick_gap((i / 50) % 3 == 1));
    end

    wait_drained();
    repeat (4) @(posedge clk);

    if (tracker.pending() > 0) begin
      tracker.errors++;
      $display("%0t: results missing, expected %0d more, actual none",
               $time, tracker.pending());
    end
    if (tracker.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/aswpa_pkg.sv
rtl/aswpa_ctrl.sv
rtl/aswpa_datapath.sv
rtl/array_stack_with_positional_access_unit.sv
dv/testbench.sv
